// ===== sv/rhgp_pkg.sv =====
`default_nettype none
package rhgp_pkg;

	// Ring geometry
	localparam int NUM_SAMPLES = 60;
	localparam int RING_AW     = $clog2(NUM_SAMPLES);

	// Divider geometry: dividend is smoothed value times height
	localparam int DIV_W  = 16;
	localparam int DIV_CW = $clog2(DIV_W + 1);
	localparam int SCL_W  = 9;

	// Reciprocal of 6 for 8-bit values: x/6 == (x*171) >> 10
	localparam int RECIP6     = 171;
	localparam int RECIP6_SHR = 10;

	// Request types
	typedef enum logic {
		REQ_PUSH   = 1'b0,
		REQ_RENDER = 1'b1
	} req_t;

	// Register byte addresses
	localparam int APB_AW = 5;
	localparam logic [APB_AW-1:0] ADDR_LEFT   = 5'd0;
	localparam logic [APB_AW-1:0] ADDR_TOP    = 5'd4;
	localparam logic [APB_AW-1:0] ADDR_HEIGHT = 5'd8;
	localparam logic [APB_AW-1:0] ADDR_XSTEP  = 5'd12;
	localparam logic [APB_AW-1:0] ADDR_MINSCL = 5'd16;

	// Control between sequencer and divider
	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [SCL_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

// ===== sv/rate_history_graph_plotter.sv =====
// Rate history graph plotter.
// Input channel (in_valid/in_ready): req_type 0 pushes sample_value into a
// ring of NUM_SAMPLES samples and advances the head; req_type 1 renders.
// Output channel (out_valid/out_ready): a render gives one point per sample,
// oldest first, with smoothed value, x/y coordinates and the ring peak; the
// final point has last_point set. A push gives no point.
// Handshake and flow: a push leaves the block in the idle state, so in_ready
// stays high for the next request. A render first scans the ring for the
// peak, forms the scale and loads the smoothing window; then, for each point,
// it smooths, multiplies, starts the shared 16-step restoring divider, waits
// while it runs and offers the point, holding while the receiver stalls.
// in_ready is low for the whole render, so no new request is taken until the
// last point is accepted.
// Stall: a point is held in the output registers until out_ready; the
// sequencer waits and resumes with the next point after acceptance.
// Reset: the ring reads as all zero, head returns to zero, registers take
// their default values. Registers are written over the APB port and must
// only change while no render is in progress.
`default_nettype none
module rate_history_graph_plotter (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         req_type,
	input  wire logic [7:0]                   sample_value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [5:0]                        point_index,
	output logic [10:0]                       point_x,
	output logic [8:0]                        point_y,
	output logic [7:0]                        smoothed_value,
	output logic [7:0]                        window_peak,
	output logic                              last_point,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rhgp_pkg::APB_AW-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import rhgp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PEAK, S_PFIN, S_SCALE, S_FILL0, S_FILL1, S_FILL2,
		S_SMOOTH, S_MUL, S_START, S_DIV, S_EMIT
	} state_t;

	localparam logic [RING_AW-1:0] LAST_POS = RING_AW'(NUM_SAMPLES - 1);

	state_t state_q;

	logic [7:0] left_q, top_q, height_q, minscl_q;
	logic [3:0] xstep_q;

	logic [RING_AW-1:0] head_q;
	logic [RING_AW-1:0] cnt_q;
	logic [7:0]         peak_q;
	logic [SCL_W-1:0]   scale_q;
	logic [7:0]         prev_q, cur_q, next_q, nbuf_q;
	logic [7:0]         sm_q;
	logic [DIV_W-1:0]   prod_q;
	logic [10:0]        x_q;

	logic [RING_AW-1:0] rd_pos;
	logic [RING_AW:0]   rd_sum;
	logic [RING_AW-1:0] rd_addr;
	logic [7:0]         rd_data;
	logic               push;
	logic               render;
	logic               emit_done;
	logic [9:0]         tap_sum;
	logic [15:0]        p171;
	logic [SCL_W-1:0]   scl_raw;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// APB register file
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= 8'd12;
			top_q    <= 8'd96;
			height_q <= 8'd34;
			xstep_q  <= 4'd2;
			minscl_q <= 8'd20;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				ADDR_LEFT:   left_q   <= pwdata[7:0];
				ADDR_TOP:    top_q    <= pwdata[7:0];
				ADDR_HEIGHT: height_q <= pwdata[7:0];
				ADDR_XSTEP:  xstep_q  <= pwdata[3:0];
				ADDR_MINSCL: minscl_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_LEFT:   prdata = {24'd0, left_q};
			ADDR_TOP:    prdata = {24'd0, top_q};
			ADDR_HEIGHT: prdata = {24'd0, height_q};
			ADDR_XSTEP:  prdata = {28'd0, xstep_q};
			ADDR_MINSCL: prdata = {24'd0, minscl_q};
			default:     prdata = 32'd0;
		endcase
	end

	// Request handshake
	assign in_ready  = (state_q == S_IDLE);
	assign push      = in_valid && in_ready && (req_type == REQ_PUSH);
	assign render    = in_valid && in_ready && (req_type == REQ_RENDER);
	assign out_valid = (state_q == S_EMIT);
	assign emit_done = out_valid && out_ready;

	// Pick the ring position to read
	always_comb begin
		unique case (state_q)
			S_PEAK:   rd_pos = cnt_q;
			S_FILL0:  rd_pos = '0;
			S_FILL1:  rd_pos = RING_AW'(1);
			S_SMOOTH: rd_pos = (cnt_q >= RING_AW'(NUM_SAMPLES - 3)) ? LAST_POS
			                                                       : cnt_q + RING_AW'(2);
			default:  rd_pos = '0;
		endcase
		rd_sum  = {1'b0, head_q} + {1'b0, rd_pos};
		rd_addr = (rd_sum >= (RING_AW+1)'(NUM_SAMPLES))
		          ? RING_AW'(rd_sum - (RING_AW+1)'(NUM_SAMPLES)) : rd_sum[RING_AW-1:0];
	end

	rhgp_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (push),
		.waddr  (head_q),
		.wdata  (sample_value),
		.raddr  (rd_addr),
		.rdata  (rd_data)
	);

	// Scale and smoothing arithmetic
	always_comb begin
		p171    = 16'(peak_q) * 16'(RECIP6);
		scl_raw = {1'b0, peak_q} + SCL_W'(p171 >> RECIP6_SHR);
		tap_sum = {2'b0, prev_q} + {1'b0, cur_q, 1'b0} + {2'b0, next_q};
	end

	assign div_req.start    = (state_q == S_START);
	assign div_req.dividend = prod_q;
	assign div_req.divisor  = scale_q;

	rhgp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			head_q         <= '0;
			cnt_q          <= '0;
			point_index    <= '0;
			point_x        <= '0;
			point_y        <= '0;
			smoothed_value <= '0;
			window_peak    <= '0;
			last_point     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (push) begin
						head_q <= (head_q == LAST_POS) ? '0 : head_q + 1'b1;
					end
					if (render) begin
						cnt_q   <= '0;
						state_q <= S_PEAK;
					end
				end
				S_PEAK: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_POS) begin
						state_q <= S_PFIN;
					end
				end
				S_PFIN:   state_q <= S_SCALE;
				S_SCALE:  state_q <= S_FILL0;
				S_FILL0: begin
					cnt_q   <= '0;
					state_q <= S_FILL1;
				end
				S_FILL1:  state_q <= S_FILL2;
				S_FILL2:  state_q <= S_SMOOTH;
				S_SMOOTH: state_q <= S_MUL;
				S_MUL:    state_q <= S_START;
				S_START:  state_q <= S_DIV;
				S_DIV: begin
					if (div_rsp.done) begin
						point_index    <= 6'(cnt_q);
						point_x        <= x_q;
						point_y        <= 9'({1'b0, top_q} + {1'b0, height_q})
						                  - {1'b0, div_rsp.quotient};
						smoothed_value <= sm_q;
						window_peak    <= peak_q;
						last_point     <= (cnt_q == LAST_POS);
						state_q        <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_done) begin
						if (cnt_q == LAST_POS) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_SMOOTH;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				peak_q <= 8'd0;
			end
			S_PEAK: begin
				if (cnt_q != '0 && rd_data > peak_q) begin
					peak_q <= rd_data;
				end
			end
			S_PFIN: begin
				if (rd_data > peak_q) begin
					peak_q <= rd_data;
				end
			end
			S_SCALE: begin
				if (scl_raw < {1'b0, minscl_q}) begin
					scale_q <= (minscl_q == 8'd0) ? SCL_W'(1) : {1'b0, minscl_q};
				end else begin
					scale_q <= (scl_raw == '0) ? SCL_W'(1) : scl_raw;
				end
			end
			S_FILL0: begin
				x_q <= {3'd0, left_q};
			end
			S_FILL1: begin
				prev_q <= rd_data;
				cur_q  <= rd_data;
			end
			S_FILL2: begin
				next_q <= rd_data;
			end
			S_SMOOTH: begin
				sm_q <= tap_sum[9:2];
			end
			S_MUL: begin
				nbuf_q <= rd_data;
				prod_q <= 16'(sm_q) * 16'(height_q);
			end
			S_START, S_DIV: ;
			S_EMIT: begin
				if (emit_done) begin
					x_q    <= x_q + {7'd0, xstep_q};
					prev_q <= cur_q;
					cur_q  <= next_q;
					next_q <= nbuf_q;
				end
			end
			default: ;
		endcase
	end

	// Checks
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted while a point is pending");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_point) |-> (point_index == 6'(NUM_SAMPLES - 1)))
		else $error("last point flagged at wrong index");

	a_y_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (point_y >= {1'b0, top_q}))
		else $error("point above graph top");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("divider finished outside divide state");

endmodule
`default_nettype wire

// ===== sv/rhgp_ring.sv =====
`default_nettype none
module rhgp_ring (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       we,
	input  wire logic [rhgp_pkg::RING_AW-1:0] waddr,
	input  wire logic [7:0]                 wdata,
	input  wire logic [rhgp_pkg::RING_AW-1:0] raddr,
	output logic [7:0]                      rdata
);
	import rhgp_pkg::*;

	logic [7:0]             mem [NUM_SAMPLES];
	logic [NUM_SAMPLES-1:0] valid_q;
	logic [7:0]             mem_rd_q;

	// Write one sample
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one sample, registered
	always_ff @(posedge clk) begin
		mem_rd_q <= mem[raddr];
	end

	// Track written slots; unwritten slots read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	logic rd_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[raddr];
		end
	end

	assign rdata = rd_valid_q ? mem_rd_q : 8'd0;

endmodule
`default_nettype wire

// ===== sv/rhgp_div.sv =====
`default_nettype none
module rhgp_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rhgp_pkg::div_req_t req,
	output rhgp_pkg::div_rsp_t      rsp
);
	import rhgp_pkg::*;

	logic [DIV_W-1:0]  dvd_q;
	logic [SCL_W-1:0]  rem_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [SCL_W:0]    trial;
	logic              qbit;

	// One restoring step per cycle
	always_comb begin
		trial = {rem_q, dvd_q[DIV_W-1]};
		qbit  = (trial >= {1'b0, req.divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift quotient bits into the dividend register
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], qbit};
			rem_q <= qbit ? SCL_W'(trial - {1'b0, req.divisor}) : trial[SCL_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q[7:0];

endmodule
`default_nettype wire
